// ----- hw/rtl/vhpd_pkg.sv -----
// ----------------------------------------------------------------------------
// vhpd_pkg
// Shared widths, register indexes, reset values and control types for the
// visual hold PD command block.
// ----------------------------------------------------------------------------
`default_nettype none

package vhpd_pkg;

    // Field widths
    localparam int RESIDUAL_BITS = 16;
    localparam int TIME_BITS     = 48;
    localparam int STATUS_W      = 2;
    localparam int GAIN_W        = 16;
    localparam int LIMIT_W       = 15;
    localparam int RADIUS_W      = 16;
    localparam int OUT_W         = 16;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_PROP_GAIN      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DERIV_GAIN     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_COMMAND_LIMIT  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_RECENTRE_RAD   = 2'd3;

    localparam logic [GAIN_W-1:0]   PROP_GAIN_RESET     = 16'd262;
    localparam logic [GAIN_W-1:0]   DERIV_GAIN_RESET    = 16'd1311;
    localparam logic [LIMIT_W-1:0]  COMMAND_LIMIT_RESET = 15'd11469;
    localparam logic [RADIUS_W-1:0] RECENTRE_RAD_RESET  = 16'd1024;

    // Tracking status codes
    localparam logic [STATUS_W-1:0] TRACK_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] TRACK_DEGRADED = 2'd1;

    // Arithmetic widths
    localparam int USEC_W = 20;
    localparam logic [USEC_W-1:0] USEC_PER_SEC = 20'd1000000;
    localparam int PROD_W     = RESIDUAL_BITS + GAIN_W + 1;
    localparam int MAG_W      = RESIDUAL_BITS + GAIN_W;
    localparam int NUM_W      = MAG_W + USEC_W;
    localparam int SUM_W      = NUM_W + 2;
    localparam int CMD_SHIFT  = 5;
    localparam int SCALED_W   = SUM_W - CMD_SHIFT;
    localparam int SQ_W       = 2 * RESIDUAL_BITS;
    localparam int DIV_CNT_W  = $clog2(NUM_W);

    // Stream packing
    localparam int IN_HOLD_POS   = 0;
    localparam int IN_STATUS_POS = 1;
    localparam int IN_SX_POS     = IN_STATUS_POS + STATUS_W;
    localparam int IN_SY_POS     = IN_SX_POS + RESIDUAL_BITS;
    localparam int IN_SP_POS     = IN_SY_POS + RESIDUAL_BITS;
    localparam int IN_TIME_POS   = IN_SP_POS + RESIDUAL_BITS;
    localparam int IN_FIELDS_W   = IN_TIME_POS + TIME_BITS;
    localparam int IN_DATA_W     = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W  = 2 * OUT_W + 2;
    localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic prep;
        logic mul1;
        logic mul2;
        logic div_step;
        logic sum;
        logic out_load;
    } vhpd_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_done;
        logic out_free;
    } vhpd_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/vhpd_ctrl.sv -----
// ----------------------------------------------------------------------------
// vhpd_ctrl
// Sequencer for one transaction: capture, prepare, two multiply steps, the
// shared-count divide, sum and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module vhpd_ctrl (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_tvalid,
    output logic                   in_tready,
    input  vhpd_pkg::vhpd_status_t status,
    output vhpd_pkg::vhpd_cmd_t    cmd
);
    import vhpd_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_MUL1 = 3'd2;
    localparam logic [2:0] S_MUL2 = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_SUM  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_tready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_starts_prep: assert property (@(posedge clk) disable iff (!rst_n)
        in_tvalid && in_tready |=> state_reg == S_PREP)
        else $error("accepted transaction did not start preparation");

    a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT && !status.out_free |=> state_reg == S_OUT)
        else $error("result left the sequencer while the output slot was full");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/vhpd_datapath.sv -----
// ----------------------------------------------------------------------------
// vhpd_datapath
// Configuration registers, hold history, PD arithmetic with two restoring
// divider lanes sharing one elapsed time, clamp and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vhpd_datapath (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_we,
    input  wire  [vhpd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire  [vhpd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire  [vhpd_pkg::IN_DATA_W-1:0]      in_tdata,
    input  wire                                 out_tready,
    input  vhpd_pkg::vhpd_cmd_t                 cmd,
    output vhpd_pkg::vhpd_status_t              status,
    output logic                                out_tvalid,
    output logic [vhpd_pkg::OUT_DATA_W-1:0]     out_tdata
);
    import vhpd_pkg::*;

    localparam int R = RESIDUAL_BITS;
    localparam int T = TIME_BITS;

    // Configuration
    logic [GAIN_W-1:0]   prop_gain_reg;
    logic [GAIN_W-1:0]   deriv_gain_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [RADIUS_W-1:0] radius_reg;

    // History
    logic                hold_was_reg;
    logic signed [R-1:0] last_x_reg;
    logic signed [R-1:0] last_f_reg;
    logic [T-1:0]        last_stamp_reg;

    // Captured input
    logic                hold_in_reg;
    logic [STATUS_W-1:0] stat_in_reg;
    logic signed [R-1:0] sx_reg;
    logic signed [R-1:0] sy_reg;
    logic signed [R-1:0] sp_reg;
    logic [T-1:0]        t_reg;

    // Prepared values
    logic                anchor_reg;
    logic                active_reg;
    logic                degr_reg;
    logic                have_d_reg;
    logic [T-1:0]        dt_reg;
    logic [R-1:0]        absdx_reg;
    logic [R-1:0]        absdf_reg;
    logic                dxneg_reg;
    logic                dfneg_reg;

    // Products
    logic signed [PROD_W-1:0] p_x_reg;
    logic signed [PROD_W-1:0] p_f_reg;
    logic [MAG_W-1:0]         mag_x_reg;
    logic [MAG_W-1:0]         mag_f_reg;
    logic signed [SQ_W-1:0]   sq_x_reg;
    logic signed [SQ_W-1:0]   sq_y_reg;
    logic                     reanchor_reg;

    // Divider lanes; num holds the dividend and shifts the quotient in
    logic [NUM_W-1:0]     num_x_reg;
    logic [NUM_W-1:0]     num_f_reg;
    logic [T-1:0]         rem_x_reg;
    logic [T-1:0]         rem_f_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;

    logic signed [SCALED_W-1:0] scaled_x_reg;
    logic signed [SCALED_W-1:0] scaled_f_reg;

    logic                 out_valid_reg;
    logic [OUT_W-1:0]     roll_reg;
    logic [OUT_W-1:0]     pitch_reg;
    logic                 anchor_out_reg;
    logic                 reanchor_out_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= PROP_GAIN_RESET;
            deriv_gain_reg <= DERIV_GAIN_RESET;
            limit_reg      <= COMMAND_LIMIT_RESET;
            radius_reg     <= RECENTRE_RAD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_PROP_GAIN:     prop_gain_reg  <= cfg_wdata[GAIN_W-1:0];
                REG_DERIV_GAIN:    deriv_gain_reg <= cfg_wdata[GAIN_W-1:0];
                REG_COMMAND_LIMIT: limit_reg      <= cfg_wdata[LIMIT_W-1:0];
                REG_RECENTRE_RAD:  radius_reg     <= cfg_wdata[RADIUS_W-1:0];
                default:           ;
            endcase
        end
    end

    // ---------------- capture ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            hold_in_reg <= in_tdata[IN_HOLD_POS];
            stat_in_reg <= in_tdata[IN_STATUS_POS +: STATUS_W];
            sx_reg      <= in_tdata[IN_SX_POS +: R];
            sy_reg      <= in_tdata[IN_SY_POS +: R];
            sp_reg      <= in_tdata[IN_SP_POS +: R];
            t_reg       <= in_tdata[IN_TIME_POS +: T];
        end
    end

    // ---------------- preparation ----------------
    logic                anchor;
    logic                active;
    logic signed [R-1:0] base_x;
    logic signed [R-1:0] base_f;
    logic [T-1:0]        base_t;
    logic                have_d;
    logic signed [R:0]   dx;
    logic signed [R:0]   df;
    logic signed [R:0]   dx_abs;
    logic signed [R:0]   df_abs;

    always_comb
    begin
        anchor = hold_in_reg && !hold_was_reg;
        active = hold_in_reg
                 && (stat_in_reg == TRACK_OK || stat_in_reg == TRACK_DEGRADED);
        base_x = anchor ? '0 : last_x_reg;
        base_f = anchor ? '0 : last_f_reg;
        base_t = anchor ? '0 : last_stamp_reg;
        // A stamp of zero means there is no usable previous time.
        have_d = active && (base_t != '0) && (t_reg > base_t);
        dx     = {sx_reg[R-1], sx_reg} - {base_x[R-1], base_x};
        df     = {sp_reg[R-1], sp_reg} - {base_f[R-1], base_f};
        dx_abs = dx[R] ? -dx : dx;
        df_abs = df[R] ? -df : df;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            anchor_reg <= anchor;
            active_reg <= active;
            degr_reg   <= hold_in_reg && (stat_in_reg == TRACK_DEGRADED);
            have_d_reg <= have_d;
            dt_reg     <= t_reg - base_t;
            absdx_reg  <= dx_abs[R-1:0];
            absdf_reg  <= df_abs[R-1:0];
            dxneg_reg  <= dx[R];
            dfneg_reg  <= df[R];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_was_reg   <= 1'b0;
            last_x_reg     <= '0;
            last_f_reg     <= '0;
            last_stamp_reg <= '0;
        end
        else if (cmd.prep)
        begin
            hold_was_reg <= hold_in_reg;
            if (active)
            begin
                last_x_reg     <= sx_reg;
                last_f_reg     <= sp_reg;
                last_stamp_reg <= t_reg;
            end
            else if (hold_in_reg)
            begin
                last_x_reg     <= base_x;
                last_f_reg     <= base_f;
                last_stamp_reg <= '0;
            end
        end
    end

    // ---------------- multiplies ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.mul1)
        begin
            p_x_reg   <= $signed({1'b0, prop_gain_reg}) * sx_reg;
            p_f_reg   <= $signed({1'b0, prop_gain_reg}) * sp_reg;
            mag_x_reg <= absdx_reg * deriv_gain_reg;
            mag_f_reg <= absdf_reg * deriv_gain_reg;
            sq_x_reg  <= sx_reg * sx_reg;
            sq_y_reg  <= sy_reg * sy_reg;
        end
    end

    logic [SQ_W:0] sq_sum;
    assign sq_sum = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};

    // ---------------- divider ----------------
    logic [T:0] trial_x;
    logic [T:0] trial_f;
    assign trial_x = {rem_x_reg, num_x_reg[NUM_W-1]} - {1'b0, dt_reg};
    assign trial_f = {rem_f_reg, num_f_reg[NUM_W-1]} - {1'b0, dt_reg};

    assign status.div_done = (cnt_reg == DIV_CNT_W'(NUM_W - 1));
    assign status.out_free = !out_valid_reg || out_tready;

    always_ff @(posedge clk)
    begin
        if (cmd.mul2)
        begin
            num_x_reg    <= NUM_W'(mag_x_reg) * NUM_W'(USEC_PER_SEC);
            num_f_reg    <= NUM_W'(mag_f_reg) * NUM_W'(USEC_PER_SEC);
            rem_x_reg    <= '0;
            rem_f_reg    <= '0;
            reanchor_reg <= degr_reg
                            && (sq_sum < {{(SQ_W + 1 - RADIUS_W){1'b0}}, radius_reg});
        end
        else if (cmd.div_step)
        begin
            // The sign of the trial difference is the borrow.
            if (!trial_x[T])
            begin
                rem_x_reg <= trial_x[T-1:0];
            end
            else
            begin
                rem_x_reg <= {rem_x_reg[T-2:0], num_x_reg[NUM_W-1]};
            end
            num_x_reg <= {num_x_reg[NUM_W-2:0], !trial_x[T]};
            if (!trial_f[T])
            begin
                rem_f_reg <= trial_f[T-1:0];
            end
            else
            begin
                rem_f_reg <= {rem_f_reg[T-2:0], num_f_reg[NUM_W-1]};
            end
            num_f_reg <= {num_f_reg[NUM_W-2:0], !trial_f[T]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.mul2)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // ---------------- sum and scale ----------------
    logic signed [SUM_W-1:0] q_x;
    logic signed [SUM_W-1:0] q_f;
    logic signed [SUM_W-1:0] d_x;
    logic signed [SUM_W-1:0] d_f;
    logic signed [SUM_W-1:0] s_x;
    logic signed [SUM_W-1:0] s_f;

    always_comb
    begin
        q_x = $signed({2'b00, num_x_reg});
        q_f = $signed({2'b00, num_f_reg});
        d_x = have_d_reg ? (dxneg_reg ? -q_x : q_x) : '0;
        d_f = have_d_reg ? (dfneg_reg ? -q_f : q_f) : '0;
        s_x = $signed({{(SUM_W - PROD_W){p_x_reg[PROD_W-1]}}, p_x_reg}) + d_x;
        s_f = $signed({{(SUM_W - PROD_W){p_f_reg[PROD_W-1]}}, p_f_reg}) + d_f;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum)
        begin
            // Dropping the low bits of a signed value rounds toward minus infinity.
            scaled_x_reg <= s_x[SUM_W-1:CMD_SHIFT];
            scaled_f_reg <= s_f[SUM_W-1:CMD_SHIFT];
        end
    end

    // ---------------- clamp ----------------
    logic signed [SCALED_W-1:0] lim_s;
    logic signed [SCALED_W-1:0] neg_lim_s;
    logic signed [SCALED_W-1:0] neg_f;
    logic [OUT_W-1:0]           roll_val;
    logic [OUT_W-1:0]           pitch_val;

    always_comb
    begin
        lim_s     = $signed({{(SCALED_W - LIMIT_W){1'b0}}, limit_reg});
        neg_lim_s = -lim_s;
        neg_f     = -scaled_f_reg;
        if (scaled_x_reg > lim_s)
        begin
            roll_val = lim_s[OUT_W-1:0];
        end
        else if (scaled_x_reg < neg_lim_s)
        begin
            roll_val = neg_lim_s[OUT_W-1:0];
        end
        else
        begin
            roll_val = scaled_x_reg[OUT_W-1:0];
        end
        // Pitch takes the negated law, so the bounds swap.
        if (scaled_f_reg < neg_lim_s)
        begin
            pitch_val = lim_s[OUT_W-1:0];
        end
        else if (scaled_f_reg > lim_s)
        begin
            pitch_val = neg_lim_s[OUT_W-1:0];
        end
        else
        begin
            pitch_val = neg_f[OUT_W-1:0];
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            roll_reg         <= active_reg ? roll_val : '0;
            pitch_reg        <= active_reg ? pitch_val : '0;
            anchor_out_reg   <= anchor_reg;
            reanchor_out_reg <= active_reg && reanchor_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_tvalid = out_valid_reg;
    assign out_tdata  = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}},
                         reanchor_out_reg, anchor_out_reg, pitch_reg, roll_reg};

`ifndef NO_ASSERTIONS
    a_anchor_clears_history: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.prep && anchor && !active
        |=> last_x_reg == '0 && last_f_reg == '0 && last_stamp_reg == '0)
        else $error("history not cleared on hold engage without tracking");

    a_release_keeps_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.prep && !hold_in_reg |=> $stable(last_stamp_reg))
        else $error("last stamp changed while hold was released");

    a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/visual_hold_pd_command.sv -----
// ----------------------------------------------------------------------------
// visual_hold_pd_command
// Position-hold PD law turning per-frame vision residuals into clamped roll
// and pitch stick commands.
// ----------------------------------------------------------------------------
// Usage:
//   One vision result per transaction enters on the s_axis channel and
//   exactly one command transaction leaves on the m_axis channel, in order.
//   Gains, the command limit and the re-anchor radius are written through
//   cfg_we/cfg_addr/cfg_wdata while no transaction is in flight.
//   After acceptance a transaction passes through preparation, two multiply
//   steps, 52 restoring divide steps (one quotient bit per cycle, the time
//   difference as divisor, both axes in parallel lanes), a sum step and the
//   hand-off to the output register, where its result becomes valid.
//   A new transaction is not accepted until the previous one has been
//   handed off to the output register.
//   s_axis_tready is high only while the sequencer is idle; the next input is
//   taken while a finished result still waits in the output register.
//   If m_axis_tready stays low, the result holds and the following
//   transaction completes its arithmetic and then waits for the slot.
//   Reset clears the hold history (no previous time) and loads the default
//   gains, limit and radius.
// ----------------------------------------------------------------------------
`default_nettype none

module visual_hold_pd_command (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_we,
    input  wire  [vhpd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire  [vhpd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // hold_on, track_status, shift_x, shift_y, spread, stamp_us, zero pad
    input  wire  [vhpd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // roll_cmd, pitch_cmd, anchor_now, reanchor_now, zero pad
    output logic [vhpd_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import vhpd_pkg::*;

    vhpd_cmd_t    cmd;
    vhpd_status_t status;

    vhpd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tvalid (s_axis_tvalid),
        .in_tready (s_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    vhpd_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_tdata   (s_axis_tdata),
        .out_tready (m_axis_tready),
        .cmd        (cmd),
        .status     (status),
        .out_tvalid (m_axis_tvalid),
        .out_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ----- sim/stick_cmd_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stick_cmd_checker
// Watches the vision input stream, the command output stream and the register
// port of the visual hold PD block. It keeps its own copy of the gains, the
// limit and the hold history, predicts the stick command of every accepted
// vision transaction, and compares each accepted command against the oldest
// prediction.
// ----------------------------------------------------------------------------
module stick_cmd_checker (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_we,
    input  wire  [vhpd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire  [vhpd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire                                s_tvalid,
    input  wire                                s_tready,
    input  wire  [vhpd_pkg::IN_DATA_W-1:0]     s_tdata,
    input  wire                                m_tvalid,
    input  wire                                m_tready,
    input  wire  [vhpd_pkg::OUT_DATA_W-1:0]    m_tdata,
    output int                                 mismatches,
    output int                                 backlog
);
    import vhpd_pkg::*;

    localparam longint unsigned RATE_CAP = 64'd1 << 56;

    // Field order from the lowest bit up: roll, pitch, anchor, reanchor.
    typedef struct packed {
        logic                    reanchor;
        logic                    anchor;
        logic signed [OUT_W-1:0] pitch;
        logic signed [OUT_W-1:0] roll;
    } stick_cmd_t;

    stick_cmd_t pending_cmds[$];

    longint          kp;
    longint          kd;
    longint          lim;
    longint          radius;
    logic            hold_was_on;
    longint          last_sx;
    longint          last_sp;
    longint unsigned last_ts;
    int              bad;

    // Proportional plus rate term, scaled down by 32 with floor rounding.
    function automatic longint pd_term(input longint err, input longint derr,
                                       input bit rate_ok, input longint unsigned dt);
        longint          acc;
        longint unsigned rate;
        acc = kp * err;
        if (rate_ok && derr != 0)
        begin
            rate = unsigned'(((derr < 0) ? -derr : derr) * kd);
            rate = rate * 64'd1000000 / dt;
            if (rate > RATE_CAP)
                rate = RATE_CAP;
            acc = (derr < 0) ? acc - $signed(rate) : acc + $signed(rate);
        end
        return acc >>> CMD_SHIFT;
    endfunction

    function automatic longint clip_stick(input longint v);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic stick_cmd_t predict_cmd(input logic [IN_DATA_W-1:0] d);
        stick_cmd_t          c;
        logic                hold;
        logic [STATUS_W-1:0] st;
        longint              sx;
        longint              sy;
        longint              sp;
        longint              ax;
        longint              ay;
        longint              roll;
        longint              pitch;
        longint unsigned     ts;
        longint unsigned     dt;
        bit                  rate_ok;
        hold = d[IN_HOLD_POS];
        st   = d[IN_STATUS_POS +: STATUS_W];
        sx   = longint'($signed(d[IN_SX_POS +: RESIDUAL_BITS]));
        sy   = longint'($signed(d[IN_SY_POS +: RESIDUAL_BITS]));
        sp   = longint'($signed(d[IN_SP_POS +: RESIDUAL_BITS]));
        ts   = 64'(d[IN_TIME_POS +: TIME_BITS]);
        c    = '0;
        c.anchor = hold && !hold_was_on;
        if (c.anchor)
        begin
            last_sx = 0;
            last_sp = 0;
            last_ts = 0;
        end
        hold_was_on = hold;
        if (hold)
        begin
            if (st == TRACK_OK || st == TRACK_DEGRADED)
            begin
                rate_ok = (last_ts != 0) && (ts > last_ts);
                dt      = rate_ok ? ts - last_ts : 64'd1;
                roll    = clip_stick(pd_term(sx, sx - last_sx, rate_ok, dt));
                pitch   = clip_stick(-pd_term(sp, sp - last_sp, rate_ok, dt));
                c.roll  = roll[OUT_W-1:0];
                c.pitch = pitch[OUT_W-1:0];
                last_sx = sx;
                last_sp = sp;
                last_ts = ts;
                if (st == TRACK_DEGRADED)
                begin
                    ax = (sx < 0) ? -sx : sx;
                    ay = (sy < 0) ? -sy : sy;
                    c.reanchor = (ax * ax + ay * ay) < radius;
                end
            end
            else
            begin
                // Losing the track drops the time base, so the next good frame
                // has no rate term.
                last_ts = 0;
            end
        end
        return c;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        stick_cmd_t want;
        stick_cmd_t seen;
        if (!rst_n)
        begin
            kp          = longint'(PROP_GAIN_RESET);
            kd          = longint'(DERIV_GAIN_RESET);
            lim         = longint'(COMMAND_LIMIT_RESET);
            radius      = longint'(RECENTRE_RAD_RESET);
            hold_was_on = 1'b0;
            last_sx     = 0;
            last_sp     = 0;
            last_ts     = 0;
            bad         = 0;
            pending_cmds.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen = m_tdata[OUT_FIELDS_W-1:0];
                if (pending_cmds.size() == 0)
                begin
                    bad++;
                    if (bad <= 10)
                        $display("%0t: unexpected command roll=%0d pitch=%0d %s%0b %s%0b",
                                 $time, seen.roll, seen.pitch,
                                 "anchor=", seen.anchor, "reanchor=", seen.reanchor);
                end
                else
                begin
                    want = pending_cmds.pop_front();
                    if (seen.roll !== want.roll || seen.pitch !== want.pitch ||
                        seen.anchor !== want.anchor || seen.reanchor !== want.reanchor)
                    begin
                        bad++;
                        if (bad <= 10)
                        begin
                            $display("%0t: command mismatch exp roll=%0d pitch=%0d %s%0b %s%0b",
                                     $time, want.roll, want.pitch,
                                     "anchor=", want.anchor, "reanchor=", want.reanchor);
                            $display("%0t:   got roll=%0d pitch=%0d anchor=%0b reanchor=%0b",
                                     $time, seen.roll, seen.pitch,
                                     seen.anchor, seen.reanchor);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_cmds.push_back(predict_cmd(s_tdata));
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_PROP_GAIN:     kp     = longint'(cfg_wdata[GAIN_W-1:0]);
                    REG_DERIV_GAIN:    kd     = longint'(cfg_wdata[GAIN_W-1:0]);
                    REG_COMMAND_LIMIT: lim    = longint'(cfg_wdata[LIMIT_W-1:0]);
                    REG_RECENTRE_RAD:  radius = longint'(cfg_wdata[RADIUS_W-1:0]);
                    default: ;
                endcase
            end
        end
        mismatches <= bad;
        backlog    <= pending_cmds.size();
    end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the visual hold PD command block. A directed set of
// frames covers hold edges, tracking states, time steps and residual extremes;
// random phases follow under different gain settings and flow-control
// patterns, including one long output hold-off. Checking is done by
// stick_cmd_checker.
// ----------------------------------------------------------------------------
module tb;
    import vhpd_pkg::*;

    localparam logic [STATUS_W-1:0] TRACK_LOST        = 2'd2;
    localparam logic [STATUS_W-1:0] TRACK_NO_KEYFRAME = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int PHASE_ITEMS    = 155;

    // Same bit layout as the input tdata; the first member is the top bits.
    typedef struct packed {
        logic [IN_DATA_W-IN_FIELDS_W-1:0] pad;
        logic [TIME_BITS-1:0]             stamp_us;
        logic [RESIDUAL_BITS-1:0]         spread;
        logic [RESIDUAL_BITS-1:0]         shift_y;
        logic [RESIDUAL_BITS-1:0]         shift_x;
        logic [STATUS_W-1:0]              track_status;
        logic                             hold_on;
    } frame_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    int                    mismatches;
    int                    backlog;
    int                    send_idle     = 0;
    int                    recv_stall    = 0;
    int                    holdoff_asked = 0;
    int                    holdoff_done  = 0;
    int                    quiet_cycles  = 0;
    logic                  hold_level    = 1'b0;
    logic [TIME_BITS-1:0]  stamp_now     = '0;

    visual_hold_pd_command uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    stick_cmd_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .backlog    (backlog)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Output side: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (holdoff_done != holdoff_asked)
            begin
                holdoff_done++;
                m_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("** visual_hold_pd_command: FAILED **");
                $finish;
            end
        end
    end

    // Offers one frame and returns in the time step of its acceptance. The
    // valid is only lowered when an idle gap is chosen, so back-to-back
    // transactions never see a low and a high in the same step.
    task automatic send_frame(input logic hold, input logic [STATUS_W-1:0] st,
                              input logic [RESIDUAL_BITS-1:0] sx,
                              input logic [RESIDUAL_BITS-1:0] sy,
                              input logic [RESIDUAL_BITS-1:0] sp,
                              input logic [TIME_BITS-1:0] ts);
        frame_t f;
        f.pad          = '0;
        f.stamp_us     = ts;
        f.spread       = sp;
        f.shift_y      = sy;
        f.shift_x      = sx;
        f.track_status = st;
        f.hold_on      = hold;
        if ($urandom_range(0, 99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= f;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic drain_stream();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (backlog != 0);
    endtask

    task automatic write_regs(input logic [CFG_DATA_W-1:0] prop,
                              input logic [CFG_DATA_W-1:0] deriv,
                              input logic [CFG_DATA_W-1:0] limit,
                              input logic [CFG_DATA_W-1:0] rad);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_PROP_GAIN;
        cfg_wdata <= prop;
        @(posedge clk);
        cfg_addr  <= REG_DERIV_GAIN;
        cfg_wdata <= deriv;
        @(posedge clk);
        cfg_addr  <= REG_COMMAND_LIMIT;
        cfg_wdata <= limit;
        @(posedge clk);
        cfg_addr  <= REG_RECENTRE_RAD;
        cfg_wdata <= rad;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [RESIDUAL_BITS-1:0] pick_residual();
        int                       r;
        logic [RESIDUAL_BITS-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            v = RESIDUAL_BITS'($urandom);
            return v;
        end
        if (r < 75)
        begin
            v = RESIDUAL_BITS'($urandom_range(0, 128));
            return v - RESIDUAL_BITS'(64);
        end
        if (r < 88)
        begin
            v = RESIDUAL_BITS'($urandom_range(0, 4096));
            return v - RESIDUAL_BITS'(2048);
        end
        case ($urandom_range(0, 3))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0001;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        logic [CFG_DATA_W-1:0] v;
        if ($urandom_range(0, 1))
            v = CFG_DATA_W'($urandom_range(0, 2047));
        else
            v = CFG_DATA_W'($urandom);
        return v;
    endfunction

    // Mostly camera-like time steps, with repeats, steps back, zero stamps and
    // jumps across the whole range mixed in.
    task automatic advance_stamp();
        int                   r;
        logic [TIME_BITS-1:0] jump;
        r = $urandom_range(0, 99);
        if (r < 45)
            stamp_now = stamp_now + TIME_BITS'($urandom_range(20000, 50000));
        else if (r < 62)
            stamp_now = stamp_now + TIME_BITS'($urandom_range(1, 64));
        else if (r < 72)
            stamp_now = stamp_now + TIME_BITS'($urandom);
        else if (r < 76)
            stamp_now = stamp_now - TIME_BITS'($urandom_range(1, 5000));
        else if (r < 80)
            stamp_now = '0;
        else if (r < 88)
        begin
            jump      = TIME_BITS'({$urandom, $urandom});
            stamp_now = jump;
        end
        else if (r < 94)
            stamp_now = {TIME_BITS{1'b1}} - TIME_BITS'($urandom_range(0, 1000000));
    endtask

    task automatic run_random(input int count);
        int                  i;
        int                  r;
        logic [STATUS_W-1:0] st;
        for (i = 0; i < count; i++)
        begin
            if (hold_level)
            begin
                if ($urandom_range(0, 99) < 5)
                    hold_level = 1'b0;
            end
            else if ($urandom_range(0, 1))
                hold_level = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 60)
                st = TRACK_OK;
            else if (r < 85)
                st = TRACK_DEGRADED;
            else if (r < 93)
                st = TRACK_LOST;
            else
                st = TRACK_NO_KEYFRAME;
            advance_stamp();
            send_frame(hold_level, st, pick_residual(), pick_residual(), pick_residual(),
                       stamp_now);
        end
    endtask

    initial
    begin : stimulus
        int ph;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames under the reset settings.
        send_frame(1'b0, TRACK_OK,          16'd100,  16'd0,    16'd0,    48'd1000);
        send_frame(1'b1, TRACK_OK,          16'h7FFF, 16'd0,    16'h8000, 48'd2000);
        send_frame(1'b1, TRACK_OK,          16'h8000, 16'h7FFF, 16'h7FFF, 48'd2001);
        send_frame(1'b1, TRACK_OK,          16'h8000, 16'h8000, 16'h7FFF, 48'd2001);
        send_frame(1'b1, TRACK_OK,          16'd5,    16'd0,    -16'sd5,  48'd1500);
        send_frame(1'b1, TRACK_DEGRADED,    16'd3,    16'd4,    16'd7,    48'd40000);
        send_frame(1'b1, TRACK_DEGRADED,    16'd32,   16'd0,    16'd7,    48'd73333);
        send_frame(1'b1, TRACK_DEGRADED,    16'd0,    -16'sd31, -16'sd9,  48'd100000);
        send_frame(1'b1, TRACK_LOST,        16'd200,  16'd0,    16'd50,   48'd133333);
        send_frame(1'b1, TRACK_OK,          16'd10,   16'd0,    16'd60,   48'd166666);
        send_frame(1'b1, TRACK_NO_KEYFRAME, 16'd12,   16'd1,    16'd61,   48'd200000);
        send_frame(1'b1, TRACK_OK,          16'd14,   16'd0,    16'd62,   48'd0);
        send_frame(1'b1, TRACK_OK,          16'd20,   16'd0,    16'd40,   48'd33333);
        send_frame(1'b1, TRACK_DEGRADED,    16'h8000, 16'h8000, 16'h8000, 48'd66666);
        send_frame(1'b0, TRACK_DEGRADED,    16'd1,    16'd1,    16'd1,    48'd99999);
        send_frame(1'b1, TRACK_OK,          16'd400,  16'd0,    -16'sd400,
                   48'hFFFF_FFFF_FFFF);
        send_frame(1'b1, TRACK_OK,          16'd500,  16'd0,    -16'sd300,
                   48'hFFFF_FFFF_FFFF);
        send_frame(1'b0, TRACK_LOST,        16'd0,    16'd0,    16'd0,    48'd5);
        send_frame(1'b1, TRACK_LOST,        16'd0,    16'd0,    16'd0,    48'd6);
        send_frame(1'b1, TRACK_OK,          16'd0,    16'd0,    16'd0,    48'd1);
        send_frame(1'b1, TRACK_OK,          16'h7FFF, 16'd0,    16'h8000, 48'd2);
        send_frame(1'b1, TRACK_DEGRADED,    16'd0,    16'd0,    16'd0,    48'd3);
        hold_level = 1'b1;
        stamp_now  = 48'd3;

        for (ph = 0; ph < 6; ph++)
        begin
            drain_stream();
            case (ph)
                0:       write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                1:       write_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000);
                default: write_regs(pick_gain(), pick_gain(), CFG_DATA_W'($urandom),
                                    CFG_DATA_W'($urandom));
            endcase
            case (ph)
                0:       begin send_idle = 0;  recv_stall = 0;  end
                1:       begin send_idle = 72; recv_stall = 0;  end
                2:       begin send_idle = 0;  recv_stall = 72; end
                3:       begin send_idle = 21; recv_stall = 21; end
                4:       begin send_idle = 0;  recv_stall = 0;  end
                default: begin send_idle = 21; recv_stall = 21; end
            endcase
            // With the input running flat out, a long output hold-off backs the
            // block up until it refuses input.
            if (ph == 0)
                holdoff_asked++;
            run_random(PHASE_ITEMS);
        end

        drain_stream();
        repeat (70) @(posedge clk);
        if (mismatches == 0 && backlog == 0)
            $display("** visual_hold_pd_command: PASSED **");
        else
            $display("** visual_hold_pd_command: FAILED **");
        $finish;
    end

endmodule
